FILE: rtl/pelco_command_frame_builder_defines.svh
// ---------------------------------------------------------------------------
// pelco command frame builder assertion macros
// shared concurrent assertion forms, clocked on clock, reset is reset
// ---------------------------------------------------------------------------
`ifndef PELCO_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define PELCO_COMMAND_FRAME_BUILDER_DEFINES_SVH

// checked only outside reset
`define PCFB_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define PCFB_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/pelco_cfb_pkg.sv
// ---------------------------------------------------------------------------
// pelco command frame builder package
// register indexes, command codes, frame constants and shared types
// ---------------------------------------------------------------------------
package pelco_cfb_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_PROTOCOL_SELECT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEVICE_ADDRESS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PAN_SPEED       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TILT_SPEED      = 2'd3;

   // input command codes
   localparam logic [3:0] CMD_STOP         = 4'd0;
   localparam logic [3:0] CMD_LEFT         = 4'd1;
   localparam logic [3:0] CMD_RIGHT        = 4'd2;
   localparam logic [3:0] CMD_UP           = 4'd3;
   localparam logic [3:0] CMD_DOWN         = 4'd4;
   localparam logic [3:0] CMD_LEFT_UP      = 4'd5;
   localparam logic [3:0] CMD_LEFT_DOWN    = 4'd6;
   localparam logic [3:0] CMD_RIGHT_UP     = 4'd7;
   localparam logic [3:0] CMD_RIGHT_DOWN   = 4'd8;
   localparam logic [3:0] CMD_ZOOM_IN      = 4'd9;
   localparam logic [3:0] CMD_ZOOM_OUT     = 4'd10;
   localparam logic [3:0] CMD_PRESET_SET   = 4'd11;
   localparam logic [3:0] CMD_PRESET_CLEAR = 4'd12;
   localparam logic [3:0] CMD_PRESET_GOTO  = 4'd13;

   // command words on the wire
   localparam logic [15:0] WIRE_LEFT         = 16'h0004;
   localparam logic [15:0] WIRE_RIGHT        = 16'h0002;
   localparam logic [15:0] WIRE_UP           = 16'h0008;
   localparam logic [15:0] WIRE_DOWN         = 16'h0010;
   localparam logic [15:0] WIRE_ZOOM_IN      = 16'h0020;
   localparam logic [15:0] WIRE_ZOOM_OUT     = 16'h0040;
   localparam logic [15:0] WIRE_PRESET_SET   = 16'h0003;
   localparam logic [15:0] WIRE_PRESET_CLEAR = 16'h0005;
   localparam logic [15:0] WIRE_PRESET_GOTO  = 16'h0007;

   localparam logic [7:0] SYNC_D = 8'hFF;
   localparam logic [7:0] STX_P  = 8'hA0;
   localparam logic [7:0] ETX_P  = 8'hAF;

   // byte positions within a frame
   localparam logic [2:0] POS_HEADER  = 3'd0;
   localparam logic [2:0] POS_ADDRESS = 3'd1;
   localparam logic [2:0] POS_CMD1    = 3'd2;
   localparam logic [2:0] POS_CMD2    = 3'd3;
   localparam logic [2:0] POS_DATA1   = 3'd4;
   localparam logic [2:0] POS_DATA2   = 3'd5;
   localparam logic [2:0] POS_TRAILER = 3'd6;
   localparam logic [2:0] POS_CHECK_P = 3'd7;

   typedef struct packed {
      logic       pelco_p;
      logic [7:0] address;
      logic [5:0] pan;
      logic [5:0] tilt;
   } cfg_type;

   typedef struct packed {
      logic       pelco_p;
      logic [7:0] header;
      logic [7:0] address;
      logic [7:0] cmd1;
      logic [7:0] cmd2;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [7:0] check;
   } frame_type;

   typedef struct packed {
      logic      known;
      frame_type frame;
   } enc_type;

endpackage

FILE: rtl/pelco_cfb_csr.sv
// ---------------------------------------------------------------------------
// pelco cfb configuration registers
// protocol select, device address, pan and tilt speed
// ---------------------------------------------------------------------------
module pelco_cfb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pelco_cfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pelco_cfb_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output pelco_cfb_pkg::cfg_type               cfg
);

   pelco_cfb_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pelco_cfb_pkg::REG_PROTOCOL_SELECT: cfg_in.pelco_p = csr_write_data[0];
            pelco_cfb_pkg::REG_DEVICE_ADDRESS:  cfg_in.address = csr_write_data;
            pelco_cfb_pkg::REG_PAN_SPEED:       cfg_in.pan     = csr_write_data[5:0];
            pelco_cfb_pkg::REG_TILT_SPEED:      cfg_in.tilt    = csr_write_data[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pelco_p <= 1'b0;
         cfg_ff.address <= 8'd1;
         cfg_ff.pan     <= 6'd31;
         cfg_ff.tilt    <= 6'd31;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/pelco_cfb_encode.sv
// ---------------------------------------------------------------------------
// pelco cfb command encoder
// maps one command to the six frame fields and the check byte
// ---------------------------------------------------------------------------
module pelco_cfb_encode (
   input  pelco_cfb_pkg::cfg_type cfg,
   input  logic [3:0]             command,
   input  logic [7:0]             preset_number,
   output pelco_cfb_pkg::enc_type enc
);

   logic [15:0] code;
   logic [7:0]  d1, d2, pan, tilt, hdr;
   logic        known;

   assign pan  = {2'b00, cfg.pan};
   assign tilt = {2'b00, cfg.tilt};

   always_comb begin
      code  = 16'd0;
      d1    = 8'd0;
      d2    = 8'd0;
      known = 1'b1;
      case (command)
         pelco_cfb_pkg::CMD_STOP: code = 16'd0;
         pelco_cfb_pkg::CMD_LEFT: begin
            code = pelco_cfb_pkg::WIRE_LEFT;  d1 = pan;
         end
         pelco_cfb_pkg::CMD_RIGHT: begin
            code = pelco_cfb_pkg::WIRE_RIGHT; d1 = pan;
         end
         pelco_cfb_pkg::CMD_UP: begin
            code = pelco_cfb_pkg::WIRE_UP;    d2 = tilt;
         end
         pelco_cfb_pkg::CMD_DOWN: begin
            code = pelco_cfb_pkg::WIRE_DOWN;  d2 = tilt;
         end
         pelco_cfb_pkg::CMD_LEFT_UP: begin
            code = pelco_cfb_pkg::WIRE_LEFT | pelco_cfb_pkg::WIRE_UP;
            d1 = pan; d2 = tilt;
         end
         pelco_cfb_pkg::CMD_LEFT_DOWN: begin
            code = pelco_cfb_pkg::WIRE_LEFT | pelco_cfb_pkg::WIRE_DOWN;
            d1 = pan; d2 = tilt;
         end
         pelco_cfb_pkg::CMD_RIGHT_UP: begin
            code = pelco_cfb_pkg::WIRE_RIGHT | pelco_cfb_pkg::WIRE_UP;
            d1 = pan; d2 = tilt;
         end
         pelco_cfb_pkg::CMD_RIGHT_DOWN: begin
            code = pelco_cfb_pkg::WIRE_RIGHT | pelco_cfb_pkg::WIRE_DOWN;
            d1 = pan; d2 = tilt;
         end
         pelco_cfb_pkg::CMD_ZOOM_IN:  code = pelco_cfb_pkg::WIRE_ZOOM_IN;
         pelco_cfb_pkg::CMD_ZOOM_OUT: code = pelco_cfb_pkg::WIRE_ZOOM_OUT;
         pelco_cfb_pkg::CMD_PRESET_SET: begin
            code = pelco_cfb_pkg::WIRE_PRESET_SET;   d2 = preset_number;
         end
         pelco_cfb_pkg::CMD_PRESET_CLEAR: begin
            code = pelco_cfb_pkg::WIRE_PRESET_CLEAR; d2 = preset_number;
         end
         pelco_cfb_pkg::CMD_PRESET_GOTO: begin
            code = pelco_cfb_pkg::WIRE_PRESET_GOTO;  d2 = preset_number;
         end
         default: known = 1'b0;
      endcase
   end

   assign hdr = cfg.pelco_p ? pelco_cfb_pkg::STX_P : pelco_cfb_pkg::SYNC_D;

   always_comb begin
      enc.known         = known;
      enc.frame.pelco_p = cfg.pelco_p;
      enc.frame.header  = hdr;
      enc.frame.address = cfg.address;
      enc.frame.cmd1    = code[15:8];
      enc.frame.cmd2    = code[7:0];
      enc.frame.data1   = d1;
      enc.frame.data2   = d2;
      // pelco-p: xor over header..data2, pelco-d: sum over address..data2
      if (cfg.pelco_p) begin
         enc.frame.check = hdr ^ cfg.address ^ code[15:8] ^ code[7:0] ^ d1 ^ d2;
      end else begin
         enc.frame.check = 8'(cfg.address + code[15:8] + code[7:0] + d1 + d2);
      end
   end

endmodule

FILE: rtl/pelco_cfb_serializer.sv
// ---------------------------------------------------------------------------
// pelco cfb frame serializer
// holds one encoded frame and sends it one byte per transfer
// ---------------------------------------------------------------------------
`include "pelco_command_frame_builder_defines.svh"

module pelco_cfb_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     frame_valid,
   input  pelco_cfb_pkg::frame_type frame,
   output logic                     frame_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_last_byte
);

   pelco_cfb_pkg::frame_type frame_ff, frame_in;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   logic       out_free, step, final_step, load;
   logic [2:0] last_idx;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_idx   = frame_ff.pelco_p ? pelco_cfb_pkg::POS_CHECK_P
                                        : pelco_cfb_pkg::POS_TRAILER;
   assign step       = busy_ff && out_free;
   assign final_step = step && (idx_ff == last_idx);
   // the next frame loads in the cycle the current one sends its last byte
   assign frame_ready = !busy_ff || final_step;
   assign load        = frame_valid && frame_ready;

   always_comb begin
      frame_in = load ? frame : frame_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = pelco_cfb_pkg::POS_HEADER;
      end else begin
         busy_in = final_step ? 1'b0 : busy_ff;
         idx_in  = step ? 3'(idx_ff + 3'd1) : idx_ff;
      end
   end

   always_comb begin
      case (idx_ff)
         pelco_cfb_pkg::POS_HEADER:  byte_in = frame_ff.header;
         pelco_cfb_pkg::POS_ADDRESS: byte_in = frame_ff.address;
         pelco_cfb_pkg::POS_CMD1:    byte_in = frame_ff.cmd1;
         pelco_cfb_pkg::POS_CMD2:    byte_in = frame_ff.cmd2;
         pelco_cfb_pkg::POS_DATA1:   byte_in = frame_ff.data1;
         pelco_cfb_pkg::POS_DATA2:   byte_in = frame_ff.data2;
         pelco_cfb_pkg::POS_TRAILER:
            byte_in = frame_ff.pelco_p ? pelco_cfb_pkg::ETX_P : frame_ff.check;
         pelco_cfb_pkg::POS_CHECK_P: byte_in = frame_ff.check;
         default:                    byte_in = frame_ff.check;
      endcase
      last_in      = (idx_ff == last_idx);
      rsp_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= pelco_cfb_pkg::POS_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (step) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

   `PCFB_ASSERT(a_idx_in_frame, busy_ff |-> (idx_ff <= last_idx), "byte index past end of frame")
   `PCFB_ASSERT(a_final_frees, final_step && !frame_valid |=> !busy_ff, "frame not released after last byte")
   `PCFB_ASSERT(a_load_restarts, load |=> (busy_ff && idx_ff == pelco_cfb_pkg::POS_HEADER), "new frame did not start at header")
   `PCFB_ASSERT_ALWAYS(a_idle_after_reset, reset |=> (!busy_ff && !rsp_valid_ff), "serializer busy after reset")

endmodule

FILE: rtl/pelco_command_frame_builder.sv
// ---------------------------------------------------------------------------
// pelco command frame builder
// camera command in, pelco-d or pelco-p serial frame out, one byte per transfer
// ---------------------------------------------------------------------------
// usage:
//   req_* takes one command and preset number per transfer; rsp_* returns
//   the frame bytes in wire order, rsp_last_byte marking the check byte.
//   csr_* writes protocol select, device address, pan and tilt speed; write
//   only while no frame is pending.
//   a command is registered, encoded into a frame register, then sent from
//   the output register, one byte per cycle while rsp_ready is high.
//   frame throughput is set by the output byte rate. the next request is
//   taken while a frame is being sent, and its frame loads in the cycle the
//   current last byte goes out.
//   unknown commands are dropped from the input register and produce no bytes.
//   when rsp_ready is low the output byte holds and requests back up after
//   one held command.
//   reset clears all valid flags and restores register defaults (pelco-d,
//   address 1, speeds 31).
// ---------------------------------------------------------------------------
module pelco_command_frame_builder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [3:0]                            req_command,
   input  logic [7:0]                            req_preset_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_frame_byte,
   output logic                                  rsp_last_byte,
   input  logic                                  csr_write_enable,
   input  logic [pelco_cfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pelco_cfb_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   pelco_cfb_pkg::cfg_type cfg;
   pelco_cfb_pkg::enc_type enc;

   logic       in_valid_ff, in_valid_in;
   logic [3:0] command_ff;
   logic [7:0] preset_ff;
   logic       frame_ready, frame_valid, in_pop, req_xfer;

   pelco_cfb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pelco_cfb_encode u_encode (
      .cfg           (cfg),
      .command       (command_ff),
      .preset_number (preset_ff),
      .enc           (enc)
   );

   // unknown commands leave the input register without reaching the serializer
   assign frame_valid = in_valid_ff && enc.known;
   assign in_pop      = in_valid_ff && (!enc.known || frame_ready);
   assign req_ready   = !in_valid_ff || in_pop;
   assign req_xfer    = req_valid && req_ready;
   assign in_valid_in = req_xfer ? 1'b1 : (in_pop ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         command_ff <= req_command;
         preset_ff  <= req_preset_number;
      end
   end

   pelco_cfb_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .frame_valid    (frame_valid),
      .frame          (enc.frame),
      .frame_ready    (frame_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
